>>> src/tms_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tms_pkg
// Shared widths, types and register indexes of the trapezoidal motion shaper.
// ----------------------------------------------------------------------------
package tms_pkg;

   localparam int unsigned DtShift       = 10;
   localparam int unsigned PosWidth      = 32;
   localparam int unsigned LimitWidth    = 31;
   localparam int unsigned CsrIndexWidth = 1;
   localparam int unsigned ProdWidth     = 2 * PosWidth;

   typedef logic signed [PosWidth-1:0]  pos_type;
   typedef logic [LimitWidth-1:0]       limit_type;
   typedef logic [CsrIndexWidth-1:0]    csr_index_type;
   typedef logic [ProdWidth-1:0]        prod_type;
   typedef logic [PosWidth-1:0]         word_type;

   localparam csr_index_type RegVelocityLimit = csr_index_type'(0);
   localparam csr_index_type RegAccelLimit    = csr_index_type'(1);

endpackage
`default_nettype wire

>>> src/tms_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tms_if
// Valid/ready channels of the motion shaper: goal, result and register write.
// ----------------------------------------------------------------------------
interface tms_req_if
   import tms_pkg::*;
   ();
   logic    valid;
   logic    ready;
   pos_type goal_position;

   modport source (output valid, output goal_position, input ready);
   modport sink (input valid, input goal_position, output ready);
endinterface

interface tms_rsp_if
   import tms_pkg::*;
   ();
   logic    valid;
   logic    ready;
   pos_type shaped_position;
   pos_type shaped_speed;
   logic    arrived;

   modport source (output valid, output shaped_position, output shaped_speed,
                   output arrived, input ready);
   modport sink (input valid, input shaped_position, input shaped_speed,
                 input arrived, output ready);
endinterface

interface tms_csr_if
   import tms_pkg::*;
   ();
   logic          valid;
   logic          ready;
   csr_index_type index;
   limit_type     data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> src/tms_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tms_mul
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module tms_mul
   import tms_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   input  wire word_type multiplicand,
   input  wire word_type multiplier,
   output logic          done,
   output prod_type      product
);

   localparam int unsigned CntWidth = $clog2(PosWidth);

   word_type                mcand_ff, mcand_in;
   word_type                hi_ff, hi_in;
   word_type                lo_ff, lo_in;
   logic [CntWidth-1:0]     cnt_ff, cnt_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [PosWidth:0]       sum;

   always_comb begin
      sum      = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mcand_ff} : '0);
      mcand_in = mcand_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         mcand_in = multiplicand;
         hi_in    = '0;
         lo_in    = multiplier;
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         hi_in  = sum[PosWidth:1];
         lo_in  = {sum[0], lo_ff[PosWidth-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntWidth'(PosWidth - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff <= mcand_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      cnt_ff   <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign product = {hi_ff, lo_ff};

endmodule
`default_nettype wire

>>> src/tms_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tms_sqrt
// Digit-serial integer square root, two radicand bits and one root bit a cycle.
// ----------------------------------------------------------------------------
module tms_sqrt
   import tms_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   input  wire prod_type radicand,
   output logic          done,
   output word_type      root
);

   localparam int unsigned CntWidth = $clog2(PosWidth);
   localparam int unsigned RemWidth = PosWidth + 1;
   localparam int unsigned CurWidth = RemWidth + 2;

   prod_type                rad_ff, rad_in;
   logic [RemWidth-1:0]     rem_ff, rem_in;
   word_type                root_ff, root_in;
   logic [CntWidth-1:0]     cnt_ff, cnt_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [CurWidth-1:0]     cur;
   logic [CurWidth-1:0]     trial;
   logic [CurWidth:0]       diff;
   logic                    fits;

   always_comb begin
      cur     = {rem_ff, rad_ff[ProdWidth-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      diff    = {1'b0, cur} - {1'b0, trial};
      fits    = ~diff[CurWidth];
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[ProdWidth-3:0], 2'b00};
         rem_in  = fits ? diff[RemWidth-1:0] : cur[RemWidth-1:0];
         root_in = {root_ff[PosWidth-2:0], fits};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CntWidth'(PosWidth - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
`default_nettype wire

>>> src/trapezoidal_motion_shaper_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trapezoidal_motion_shaper_core
// Shapes a stream of goal positions into a trapezoidal velocity profile.
//
//   Channel  Direction  Beat contents
//   req_ch   in         goal_position
//   rsp_ch   out        shaped_position, shaped_speed, arrived
//   csr_ch   in         index (0 velocity_limit, 1 accel_limit), data
//
// A goal beat is taken in S_IDLE. A tick that snaps on the tolerance test then
// passes S_DIST, S_ABS and S_CHECK and goes straight to S_FIN; any other tick
// also runs the serial multiplier and then the serial square root, one after
// the other, and the steps from S_ALLOW to S_REM before S_FIN.
// One tick is in flight at a time; the next goal is taken while the result
// beat still waits in the output register, and a stalled result beat holds
// the following tick in its last state until the output register frees.
// Reset clears both limits, the position, the speed and the control state.
// ----------------------------------------------------------------------------
module trapezoidal_motion_shaper_core
   import tms_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   tms_req_if.sink   req_ch,
   tms_rsp_if.source rsp_ch,
   tms_csr_if.sink   csr_ch
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DIST  = 4'd1;
   localparam logic [3:0] S_ABS   = 4'd2;
   localparam logic [3:0] S_CHECK = 4'd3;
   localparam logic [3:0] S_MUL   = 4'd4;
   localparam logic [3:0] S_SQRT  = 4'd5;
   localparam logic [3:0] S_ALLOW = 4'd6;
   localparam logic [3:0] S_DV    = 4'd7;
   localparam logic [3:0] S_SPD   = 4'd8;
   localparam logic [3:0] S_STEP  = 4'd9;
   localparam logic [3:0] S_NEXT  = 4'd10;
   localparam logic [3:0] S_REM   = 4'd11;
   localparam logic [3:0] S_FIN   = 4'd12;

   localparam logic signed [PosWidth:0] StepBias = (33'sd1 <<< DtShift) - 33'sd1;

   logic [3:0]              state_ff, state_in;
   limit_type               vel_ff, vel_in;
   limit_type               acc_ff, acc_in;
   pos_type                 pos_ff, pos_in;
   pos_type                 spd_ff, spd_in;
   pos_type                 goal_ff, goal_in;
   logic signed [PosWidth:0] dist_ff, dist_in;
   word_type                abs_ff, abs_in;
   pos_type                 desired_ff, desired_in;
   logic signed [PosWidth:0] dv_ff, dv_in;
   pos_type                 step_ff, step_in;
   pos_type                 next_ff, next_in;
   pos_type                 res_pos_ff, res_pos_in;
   pos_type                 res_spd_ff, res_spd_in;
   logic                    res_arr_ff, res_arr_in;
   pos_type                 out_pos_ff, out_pos_in;
   pos_type                 out_spd_ff, out_spd_in;
   logic                    out_arr_ff, out_arr_in;
   logic                    out_valid_ff, out_valid_in;

   logic                    mul_start;
   logic                    mul_done;
   prod_type                mul_product;
   logic                    sqrt_start;
   logic                    sqrt_done;
   word_type                sqrt_root;

   limit_type               tol;
   limit_type               max_dv;
   limit_type               allowed;
   logic signed [PosWidth:0] max_dv_s;
   logic signed [PosWidth:0] neg_max_dv;
   logic signed [PosWidth:0] dv_clamped;
   logic signed [PosWidth:0] wide_sum;
   logic signed [PosWidth:0] rem;
   logic                    out_free;
   logic                    tick_snap;

   tms_mul u_mul (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_start),
      .multiplicand ({acc_ff, 1'b0}),
      .multiplier   (abs_ff),
      .done         (mul_done),
      .product      (mul_product)
   );

   tms_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (mul_product),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;
   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.shaped_position = out_pos_ff;
   assign rsp_ch.shaped_speed    = out_spd_ff;
   assign rsp_ch.arrived         = out_arr_ff;

   always_comb begin
      tol        = vel_ff >> (DtShift + 1);
      max_dv     = acc_ff >> DtShift;
      max_dv_s   = {2'b00, max_dv};
      neg_max_dv = -max_dv_s;
      allowed    = ({1'b0, vel_ff} < sqrt_root) ? vel_ff : sqrt_root[LimitWidth-1:0];
      out_free   = ~out_valid_ff | rsp_ch.ready;
      mul_start  = 1'b0;
      sqrt_start = 1'b0;
      dv_clamped = dv_ff;
      wide_sum   = '0;
      rem        = '0;
      tick_snap  = 1'b0;

      state_in     = state_ff;
      vel_in       = vel_ff;
      acc_in       = acc_ff;
      pos_in       = pos_ff;
      spd_in       = spd_ff;
      goal_in      = goal_ff;
      dist_in      = dist_ff;
      abs_in       = abs_ff;
      desired_in   = desired_ff;
      dv_in        = dv_ff;
      step_in      = step_ff;
      next_in      = next_ff;
      res_pos_in   = res_pos_ff;
      res_spd_in   = res_spd_ff;
      res_arr_in   = res_arr_ff;
      out_pos_in   = out_pos_ff;
      out_spd_in   = out_spd_ff;
      out_arr_in   = out_arr_ff;
      out_valid_in = out_valid_ff & ~rsp_ch.ready;

      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            RegVelocityLimit: vel_in = csr_ch.data;
            RegAccelLimit:    acc_in = csr_ch.data;
            default:          vel_in = vel_ff;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               goal_in  = req_ch.goal_position;
               state_in = S_DIST;
            end
         end
         S_DIST: begin
            dist_in  = {goal_ff[PosWidth-1], goal_ff} - {pos_ff[PosWidth-1], pos_ff};
            state_in = S_ABS;
         end
         S_ABS: begin
            abs_in   = dist_ff[PosWidth] ? word_type'(-dist_ff) : dist_ff[PosWidth-1:0];
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (abs_ff <= {1'b0, tol}) begin
               res_pos_in = goal_ff;
               res_spd_in = '0;
               res_arr_in = 1'b1;
               state_in   = S_FIN;
            end else begin
               mul_start = 1'b1;
               state_in  = S_MUL;
            end
         end
         S_MUL: begin
            if (mul_done) begin
               sqrt_start = 1'b1;
               state_in   = S_SQRT;
            end
         end
         S_SQRT: begin
            if (sqrt_done) begin
               state_in = S_ALLOW;
            end
         end
         S_ALLOW: begin
            desired_in = dist_ff[PosWidth] ? -pos_type'({1'b0, allowed})
                                           : pos_type'({1'b0, allowed});
            state_in   = S_DV;
         end
         S_DV: begin
            dv_in    = {desired_ff[PosWidth-1], desired_ff} - {spd_ff[PosWidth-1], spd_ff};
            state_in = S_SPD;
         end
         S_SPD: begin
            priority if (dv_ff > max_dv_s) begin
               dv_clamped = max_dv_s;
            end else if (dv_ff < neg_max_dv) begin
               dv_clamped = neg_max_dv;
            end else begin
               dv_clamped = dv_ff;
            end
            wide_sum   = {spd_ff[PosWidth-1], spd_ff} + dv_clamped;
            res_spd_in = wide_sum[PosWidth-1:0];
            state_in   = S_STEP;
         end
         S_STEP: begin
            wide_sum = {res_spd_ff[PosWidth-1], res_spd_ff}
                       + (res_spd_ff[PosWidth-1] ? StepBias : '0);
            wide_sum = wide_sum >>> DtShift;
            step_in  = wide_sum[PosWidth-1:0];
            state_in = S_NEXT;
         end
         S_NEXT: begin
            wide_sum = {pos_ff[PosWidth-1], pos_ff} + {step_ff[PosWidth-1], step_ff};
            if (wide_sum[PosWidth] != wide_sum[PosWidth-1]) begin
               next_in = wide_sum[PosWidth] ? {1'b1, {(PosWidth-1){1'b0}}}
                                            : {1'b0, {(PosWidth-1){1'b1}}};
            end else begin
               next_in = wide_sum[PosWidth-1:0];
            end
            state_in = S_REM;
         end
         S_REM: begin
            rem       = {goal_ff[PosWidth-1], goal_ff} - {next_ff[PosWidth-1], next_ff};
            tick_snap = (rem == '0) || (rem[PosWidth] != dist_ff[PosWidth]);
            if (tick_snap) begin
               res_pos_in = goal_ff;
               res_spd_in = '0;
               res_arr_in = 1'b1;
            end else begin
               res_pos_in = next_ff;
               res_arr_in = 1'b0;
            end
            state_in = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               pos_in       = res_pos_ff;
               spd_in       = res_spd_ff;
               out_pos_in   = res_pos_ff;
               out_spd_in   = res_spd_ff;
               out_arr_in   = res_arr_ff;
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      goal_ff    <= goal_in;
      dist_ff    <= dist_in;
      abs_ff     <= abs_in;
      desired_ff <= desired_in;
      dv_ff      <= dv_in;
      step_ff    <= step_in;
      next_ff    <= next_in;
      res_pos_ff <= res_pos_in;
      res_spd_ff <= res_spd_in;
      res_arr_ff <= res_arr_in;
      out_pos_ff <= out_pos_in;
      out_spd_ff <= out_spd_in;
      out_arr_ff <= out_arr_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         vel_ff       <= '0;
         acc_ff       <= '0;
         pos_ff       <= '0;
         spd_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vel_ff       <= vel_in;
         acc_ff       <= acc_in;
         pos_ff       <= pos_in;
         spd_ff       <= spd_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule
`default_nettype wire

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for trapezoidal_motion_shaper_core. Goal beats go in
// on the request channel and a built-in model of the shaper, with its own
// position, speed and limits, predicts each result beat. Directed ticks cover
// zero limits, full-scale limits and goals, the snap tolerance edge, stalled
// steps and a step that crosses the goal. Random move sequences then run
// under many limit settings with changing idle and stall patterns.
// ----------------------------------------------------------------------------
module testbench;
   import tms_pkg::*;

   localparam int unsigned WatchdogLimit = 2000;
   localparam int unsigned SettleCycles  = 80;
   localparam int unsigned MaxPrinted    = 20;
   localparam longint      WordMax       = 64'sd2147483647;
   localparam longint      WordMin       = -64'sd2147483648;
   localparam limit_type   LimitMax      = '1;
   localparam pos_type     GoalMax       = 32'sh7FFF_FFFF;
   localparam pos_type     GoalMin       = 32'sh8000_0000;

   typedef struct {
      pos_type position;
      pos_type speed;
      logic    arrived;
   } tick_result_type;

   logic clock;
   logic reset;

   tms_req_if req_ch ();
   tms_rsp_if rsp_ch ();
   tms_csr_if csr_ch ();

   trapezoidal_motion_shaper_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   limit_type       velocity_limit_q = '0;
   limit_type       accel_limit_q    = '0;
   pos_type         position_q       = '0;
   pos_type         speed_q          = '0;
   tick_result_type pending_ticks[$];
   tick_result_type oldest_tick;
   bit              last_arrived;
   int unsigned     send_idle_pct    = 0;
   int unsigned     rsp_stall_pct    = 0;
   int unsigned     n_sent           = 0;
   int unsigned     n_results        = 0;
   int unsigned     n_arrivals       = 0;
   int unsigned     n_settings       = 0;
   int unsigned     n_errors         = 0;
   int unsigned     quiet_cycles     = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint clamp_word(longint v);
      if (v > WordMax) return WordMax;
      if (v < WordMin) return WordMin;
      return v;
   endfunction

   // One control tick of the shaper; updates the tracked position and speed.
   function automatic tick_result_type advance_shaper(pos_type goal);
      longint g, p, s, d, desired, max_dv, dv, nxt, rem, step_q;
      longint unsigned dist_mag, tol, radicand, root, bitq, allowed, mag;
      bit snap;
      tick_result_type r;
      g = goal;
      p = position_q;
      s = speed_q;
      d = g - p;
      dist_mag = (d < 0) ? -d : d;
      tol = velocity_limit_q >> (DtShift + 1);
      snap = (dist_mag <= tol);
      if (!snap) begin
         radicand = 64'd2 * accel_limit_q * dist_mag;
         root = 0;
         bitq = 64'd1 << 62;
         while (bitq > radicand) bitq >>= 2;
         while (bitq != 0) begin
            if (radicand >= root + bitq) begin
               radicand -= root + bitq;
               root = (root >> 1) + bitq;
            end else begin
               root >>= 1;
            end
            bitq >>= 2;
         end
         allowed = (velocity_limit_q < root) ? velocity_limit_q : root;
         desired = (d < 0) ? -longint'(allowed) : longint'(allowed);
         max_dv = accel_limit_q >> DtShift;
         dv = desired - s;
         if (dv > max_dv) dv = max_dv;
         if (dv < -max_dv) dv = -max_dv;
         s = clamp_word(s + dv);
         mag = ((s < 0) ? -s : s) >> DtShift;
         step_q = (s < 0) ? -longint'(mag) : longint'(mag);
         nxt = clamp_word(p + step_q);
         rem = g - nxt;
         if (rem == 0 || ((rem < 0) != (d < 0))) begin
            snap = 1'b1;
         end else begin
            p = nxt;
         end
      end
      if (snap) begin
         p = g;
         s = 0;
      end
      position_q = pos_type'(p);
      speed_q = pos_type'(s);
      r.position = position_q;
      r.speed = speed_q;
      r.arrived = snap;
      return r;
   endfunction

   function automatic limit_type random_limit();
      unique case ($urandom_range(7))
         0: return '0;
         1: return LimitMax;
         2: return limit_type'($urandom_range(1, 1023));
         3, 4: return limit_type'($urandom());
         default: return limit_type'((64'd1 << $urandom_range(11, 30)) + $urandom_range(0, 4095));
      endcase
   endfunction

   task automatic report_mismatch(string msg);
      n_errors++;
      if (n_errors <= MaxPrinted) $display("MISMATCH: %s", msg);
   endtask

   task automatic set_idling(int unsigned send_pct, int unsigned rsp_pct);
      send_idle_pct = send_pct;
      rsp_stall_pct = rsp_pct;
   endtask

   task automatic send_goal(pos_type goal);
      tick_result_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.goal_position <= goal;
      do @(posedge clock); while (!req_ch.ready);
      r = advance_shaper(goal);
      last_arrived = r.arrived;
      pending_ticks.push_back(r);
      n_sent++;
   endtask

   task automatic wait_results_done();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_ticks.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type reg_index, limit_type value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= reg_index;
      csr_ch.data <= value;
      do @(posedge clock); while (!csr_ch.ready);
      if (reg_index == RegVelocityLimit) begin
         velocity_limit_q = value;
      end else begin
         accel_limit_q = value;
      end
   endtask

   task automatic write_limits(limit_type vel, limit_type acc);
      wait_results_done();
      write_register(RegVelocityLimit, vel);
      write_register(RegAccelLimit, acc);
      csr_ch.valid <= 1'b0;
      n_settings++;
   endtask

   task automatic test_idle_limits();
      send_goal('0);
      send_goal(pos_type'(5));
      send_goal(GoalMax);
      send_goal(GoalMin);
      send_goal('0);
   endtask

   task automatic test_full_scale();
      longint tol;
      write_limits(LimitMax, LimitMax);
      tol = LimitMax >> (DtShift + 1);
      repeat (2) send_goal(GoalMax);
      repeat (2) send_goal(GoalMin);
      send_goal(position_q);
      send_goal(pos_type'(clamp_word(position_q + tol)));
      send_goal(pos_type'(clamp_word(position_q + tol + 1)));
   endtask

   task automatic test_stalled_step();
      write_limits(limit_type'(1 << 20), limit_type'(5120));
      repeat (3) send_goal(pos_type'(clamp_word(position_q + 1000)));
   endtask

   task automatic test_crossing_snap();
      write_limits(limit_type'(1 << 24), LimitMax);
      repeat (8) send_goal(pos_type'(clamp_word(position_q + (64'sd1 << 26))));
      send_goal(pos_type'(clamp_word(position_q + 12000)));
   endtask

   task automatic test_random_profiles(int unsigned n_ticks);
      int unsigned sent, hold, kind;
      longint span, tol, scaled;
      limit_type vel, acc;
      pos_type goal;
      sent = 0;
      while (sent < n_ticks) begin
         if (sent == 0 || $urandom_range(99) < 6) begin
            vel = random_limit();
            if ($urandom_range(1)) begin
               acc = random_limit();
            end else begin
               scaled = longint'(vel) * $urandom_range(16, 256);
               acc = (scaled > longint'(LimitMax)) ? LimitMax : limit_type'(scaled);
            end
            write_limits(vel, acc);
         end else if ($urandom_range(99) < 5) begin
            wait_results_done();
         end
         kind = $urandom_range(99);
         tol = velocity_limit_q >> (DtShift + 1);
         if (kind < 70) begin
            span = longint'(velocity_limit_q >> DtShift) * $urandom_range(1, 40)
                   + $urandom_range(0, 1023);
            if ($urandom_range(1)) span = -span;
            goal = pos_type'(clamp_word(position_q + span));
            hold = $urandom_range(4, 60);
         end else if (kind < 80) begin
            goal = pos_type'($urandom());
            hold = $urandom_range(1, 4);
         end else if (kind < 88) begin
            goal = $urandom_range(1) ? GoalMax : GoalMin;
            hold = $urandom_range(4, 60);
         end else begin
            span = longint'($urandom_range(0, 2 * tol + 2)) - tol - 1;
            goal = pos_type'(clamp_word(position_q + span));
            hold = $urandom_range(1, 3);
         end
         while (hold != 0 && sent < n_ticks) begin
            send_goal(goal);
            sent++;
            hold--;
            if (last_arrived && $urandom_range(3) != 0) hold = 0;
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_ch.ready <= !reset && ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_ticks.size() == 0) begin
            report_mismatch($sformatf("result beat with no tick pending (position %0d)",
                                      rsp_ch.shaped_position));
         end else begin
            oldest_tick = pending_ticks.pop_front();
            if (rsp_ch.shaped_position !== oldest_tick.position)
               report_mismatch($sformatf("tick %0d shaped_position: got %0d, expected %0d",
                                         n_results, rsp_ch.shaped_position,
                                         oldest_tick.position));
            if (rsp_ch.shaped_speed !== oldest_tick.speed)
               report_mismatch($sformatf("tick %0d shaped_speed: got %0d, expected %0d",
                                         n_results, rsp_ch.shaped_speed, oldest_tick.speed));
            if (rsp_ch.arrived !== oldest_tick.arrived)
               report_mismatch($sformatf("tick %0d arrived: got %b, expected %b",
                                         n_results, rsp_ch.arrived, oldest_tick.arrived));
            if (oldest_tick.arrived) n_arrivals++;
            n_results++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("TIMEOUT: no beat moved for %0d cycles, %0d results outstanding",
                  quiet_cycles, pending_ticks.size());
         $display("** trapezoidal_motion_shaper_core: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.goal_position <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= RegVelocityLimit;
      csr_ch.data <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      set_idling(20, 65);
      test_idle_limits();
      test_full_scale();
      test_stalled_step();
      test_crossing_snap();
      test_random_profiles(445);
      set_idling(65, 20);
      test_random_profiles(445);
      set_idling(0, 0);
      test_random_profiles(440);

      wait_results_done();
      repeat (SettleCycles) @(posedge clock);
      $display("Drove %0d goal ticks under %0d limit settings; %0d ticks snapped to the goal.",
               n_sent, n_settings, n_arrivals);
      $display("Checked %0d result beats, %0d mismatches.", n_results, n_errors);
      if (n_errors == 0) begin
         $display("** trapezoidal_motion_shaper_core: PASSED **");
      end else begin
         $display("** trapezoidal_motion_shaper_core: FAILED **");
      end
      $finish;
   end

endmodule
